[design/lfps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, widths and codes for the line follower PID steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

   // integral accumulator width
   localparam int INTEGRAL_BITS = 16;

   // working widths derived from the integral width
   localparam int SUM_W = ((INTEGRAL_BITS > 9) ? INTEGRAL_BITS : 9) + 1;
   localparam int PID_W = ((INTEGRAL_BITS > 14) ? INTEGRAL_BITS : 14) + 6;
   localparam int SPD_W = PID_W + 1;

   // integral saturation limits at the widened sum width
   localparam logic signed [SUM_W-1:0] SUM_MAX =
      {{(SUM_W-INTEGRAL_BITS+1){1'b0}}, {(INTEGRAL_BITS-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SPEED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_BAND    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_BAND    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STRAIGHT_BAND = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_CEILING = 3'd7;

   // register reset values
   localparam logic [3:0] RST_PROP_GAIN     = 4'd2;
   localparam logic [3:0] RST_INTEG_GAIN    = 4'd0;
   localparam logic [3:0] RST_DERIV_GAIN    = 4'd4;
   localparam logic [7:0] RST_BASE_SPEED    = 8'd90;
   localparam logic [9:0] RST_INNER_BAND    = 10'd70;
   localparam logic [9:0] RST_OUTER_BAND    = 10'd130;
   localparam logic [9:0] RST_STRAIGHT_BAND = 10'd20;
   localparam logic [7:0] RST_SPEED_CEILING = 8'd250;

   // wheel direction codes
   localparam logic [3:0] DIR_STOP       = 4'h0;
   localparam logic [3:0] DIR_SOFT_LEFT  = 4'h4;
   localparam logic [3:0] DIR_SPIN_LEFT  = 4'h5;
   localparam logic [3:0] DIR_FORWARD    = 4'h6;
   localparam logic [3:0] DIR_SPIN_RIGHT = 4'hA;

   // sensor pattern thresholds
   localparam logic [7:0] CENTER_SEEN = 8'd20;
   localparam logic [7:0] DARK_LEVEL  = 8'd100;
   localparam logic [7:0] DEEP_LEVEL  = 8'd130;

   typedef struct packed {
      logic [3:0] prop_gain;
      logic [3:0] integ_gain;
      logic [3:0] deriv_gain;
      logic [7:0] base_speed;
      logic [9:0] inner_band;
      logic [9:0] outer_band;
      logic [9:0] straight_band;
      logic [7:0] speed_ceiling;
   } cfg_type;

   typedef struct packed {
      logic [7:0] left_sample;
      logic [7:0] center_sample;
      logic [7:0] right_sample;
   } req_type;

   typedef struct packed {
      logic [3:0] wheel_direction;
      logic [7:0] left_speed;
      logic [7:0] right_speed;
      logic       dwell;
   } rsp_type;

   // controller memory between samples
   typedef struct packed {
      logic signed [INTEGRAL_BITS-1:0] error_sum;
      logic signed [8:0]               last_error;
   } pid_state_type;

   // steering memory between samples
   typedef struct packed {
      logic [7:0] held_left_speed;
      logic [7:0] held_right_speed;
      logic [3:0] held_direction;
   } steer_state_type;

endpackage

[design/lfps_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_csr
// Configuration register file: gains, base speed, band edges and ceiling.
// ----------------------------------------------------------------------------
module lfps_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lfps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfps_pkg::CSR_DATA_W-1:0] csr_data,
   output lfps_pkg::cfg_type               cfg
);

   lfps_pkg::cfg_type cfg_ff;
   lfps_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            lfps_pkg::REG_PROP_GAIN:     cfg_in.prop_gain     = csr_data[3:0];
            lfps_pkg::REG_INTEG_GAIN:    cfg_in.integ_gain    = csr_data[3:0];
            lfps_pkg::REG_DERIV_GAIN:    cfg_in.deriv_gain    = csr_data[3:0];
            lfps_pkg::REG_BASE_SPEED:    cfg_in.base_speed    = csr_data[7:0];
            lfps_pkg::REG_INNER_BAND:    cfg_in.inner_band    = csr_data[9:0];
            lfps_pkg::REG_OUTER_BAND:    cfg_in.outer_band    = csr_data[9:0];
            lfps_pkg::REG_STRAIGHT_BAND: cfg_in.straight_band = csr_data[9:0];
            lfps_pkg::REG_SPEED_CEILING: cfg_in.speed_ceiling = csr_data[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= lfps_pkg::RST_PROP_GAIN;
         cfg_ff.integ_gain    <= lfps_pkg::RST_INTEG_GAIN;
         cfg_ff.deriv_gain    <= lfps_pkg::RST_DERIV_GAIN;
         cfg_ff.base_speed    <= lfps_pkg::RST_BASE_SPEED;
         cfg_ff.inner_band    <= lfps_pkg::RST_INNER_BAND;
         cfg_ff.outer_band    <= lfps_pkg::RST_OUTER_BAND;
         cfg_ff.straight_band <= lfps_pkg::RST_STRAIGHT_BAND;
         cfg_ff.speed_ceiling <= lfps_pkg::RST_SPEED_CEILING;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/lfps_pid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pid
// Line error, saturating integral, derivative and the gain-weighted sum.
// ----------------------------------------------------------------------------
module lfps_pid (
   input  lfps_pkg::req_type                    req,
   input  lfps_pkg::cfg_type                    cfg,
   input  lfps_pkg::pid_state_type              state,
   output lfps_pkg::pid_state_type              state_next,
   output logic signed [lfps_pkg::PID_W-1:0]    pid
);

   logic signed [8:0]                          err;
   logic signed [9:0]                          diff;
   logic signed [lfps_pkg::SUM_W-1:0]          sum_wide;
   logic signed [lfps_pkg::INTEGRAL_BITS-1:0]  sum_sat;
   logic signed [4:0]                          kp_s;
   logic signed [4:0]                          ki_s;
   logic signed [4:0]                          kd_s;
   logic signed [13:0]                         p_prod;
   logic signed [lfps_pkg::INTEGRAL_BITS+4:0]  i_prod;
   logic signed [14:0]                         d_prod;
   logic signed [lfps_pkg::PID_W-1:0]          p_ext;
   logic signed [lfps_pkg::PID_W-1:0]          i_ext;
   logic signed [lfps_pkg::PID_W-1:0]          d_ext;

   // error is left minus right, derivative against the previous error
   assign err  = signed'({1'b0, req.left_sample}) - signed'({1'b0, req.right_sample});
   assign diff = 10'(err) - 10'(state.last_error);

   // integral with saturation at the accumulator limits
   assign sum_wide = lfps_pkg::SUM_W'(state.error_sum) + lfps_pkg::SUM_W'(err);
   always_comb begin
      if (sum_wide > lfps_pkg::SUM_MAX) begin
         sum_sat = lfps_pkg::SUM_MAX[lfps_pkg::INTEGRAL_BITS-1:0];
      end else if (sum_wide < lfps_pkg::SUM_MIN) begin
         sum_sat = lfps_pkg::SUM_MIN[lfps_pkg::INTEGRAL_BITS-1:0];
      end else begin
         sum_sat = sum_wide[lfps_pkg::INTEGRAL_BITS-1:0];
      end
   end

   // three small gain products
   assign kp_s   = signed'({1'b0, cfg.prop_gain});
   assign ki_s   = signed'({1'b0, cfg.integ_gain});
   assign kd_s   = signed'({1'b0, cfg.deriv_gain});
   assign p_prod = kp_s * err;
   assign i_prod = ki_s * sum_sat;
   assign d_prod = kd_s * diff;

   // weighted sum
   assign p_ext = lfps_pkg::PID_W'(p_prod);
   assign i_ext = lfps_pkg::PID_W'(i_prod);
   assign d_ext = lfps_pkg::PID_W'(d_prod);
   assign pid   = p_ext + i_ext + d_ext;

   assign state_next.error_sum  = sum_sat;
   assign state_next.last_error = err;

endmodule

[design/lfps_steer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_steer
// Band rules, speed clamp and pattern overrides that give the wheel command.
// ----------------------------------------------------------------------------
module lfps_steer (
   input  lfps_pkg::req_type                  req,
   input  lfps_pkg::cfg_type                  cfg,
   input  logic signed [lfps_pkg::PID_W-1:0]  pid,
   input  lfps_pkg::steer_state_type          state,
   output lfps_pkg::steer_state_type          state_next,
   output lfps_pkg::rsp_type                  rsp
);

   logic signed [lfps_pkg::PID_W-1:0] in_b;
   logic signed [lfps_pkg::PID_W-1:0] out_b;
   logic signed [lfps_pkg::PID_W-1:0] st_b;
   logic signed [lfps_pkg::SPD_W-1:0] s_x;
   logic signed [lfps_pkg::SPD_W-1:0] pid_x;
   logic signed [lfps_pkg::SPD_W-1:0] s_plus;
   logic signed [lfps_pkg::SPD_W-1:0] s_minus;
   logic signed [lfps_pkg::SPD_W-1:0] lm;
   logic signed [lfps_pkg::SPD_W-1:0] rm;
   logic [3:0]                        dir;
   logic [7:0]                        held_l;
   logic [7:0]                        held_r;

   // clamp a speed to 0..ceiling
   function automatic logic [7:0] clamp_speed(
      input logic signed [lfps_pkg::SPD_W-1:0] v,
      input logic [7:0]                        ceiling
   );
      logic signed [lfps_pkg::SPD_W-1:0] top;
      logic [7:0]                        res;
      top = lfps_pkg::SPD_W'({1'b0, ceiling});
      if (v > top) begin
         res = ceiling;
      end else if (v < 0) begin
         res = 8'd0;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   assign in_b    = lfps_pkg::PID_W'({1'b0, cfg.inner_band});
   assign out_b   = lfps_pkg::PID_W'({1'b0, cfg.outer_band});
   assign st_b    = lfps_pkg::PID_W'({1'b0, cfg.straight_band});
   assign s_x     = lfps_pkg::SPD_W'({1'b0, cfg.base_speed});
   assign pid_x   = lfps_pkg::SPD_W'(pid);
   assign s_plus  = s_x + pid_x;
   assign s_minus = s_x - pid_x;

   // band rules, first match wins; on a band edge the held speeds stay
   always_comb begin
      dir = state.held_direction;
      if (req.center_sample > lfps_pkg::CENTER_SEEN) begin
         dir = lfps_pkg::DIR_FORWARD;
      end
      lm = lfps_pkg::SPD_W'({1'b0, state.held_left_speed});
      rm = lfps_pkg::SPD_W'({1'b0, state.held_right_speed});
      if (pid > -in_b && pid < in_b) begin
         lm = s_minus;
         rm = s_plus;
      end else if (pid > in_b && pid < out_b) begin
         lm = '0;
         rm = s_plus;
      end else if (pid > -out_b && pid < -in_b) begin
         lm = s_minus;
         rm = '0;
      end else if (pid > out_b) begin
         dir = lfps_pkg::DIR_SPIN_LEFT;
         lm  = s_plus;
         rm  = s_plus;
      end else if (pid < -out_b) begin
         dir = lfps_pkg::DIR_SPIN_RIGHT;
         lm  = s_minus;
         rm  = s_minus;
      end
   end

   assign held_l = clamp_speed(lm, cfg.speed_ceiling);
   assign held_r = clamp_speed(rm, cfg.speed_ceiling);

   // pattern overrides drive base speed unclamped
   always_comb begin
      state_next.held_left_speed  = held_l;
      state_next.held_right_speed = held_r;
      state_next.held_direction   = dir;
      rsp.left_speed              = cfg.base_speed;
      rsp.right_speed             = cfg.base_speed;
      rsp.dwell                   = 1'b0;
      if (pid < st_b && pid > -st_b) begin
         state_next.held_direction = lfps_pkg::DIR_FORWARD;
      end else if (req.left_sample > lfps_pkg::DARK_LEVEL
                   && req.center_sample > lfps_pkg::DARK_LEVEL
                   && req.right_sample > lfps_pkg::DARK_LEVEL) begin
         // all black
         state_next.held_direction = lfps_pkg::DIR_FORWARD;
         rsp.dwell                 = 1'b1;
      end else if (req.left_sample < lfps_pkg::DARK_LEVEL
                   && req.center_sample > lfps_pkg::DEEP_LEVEL
                   && req.right_sample > lfps_pkg::DEEP_LEVEL) begin
         // junction to the right of a clear left
         state_next.held_direction = lfps_pkg::DIR_SOFT_LEFT;
         rsp.dwell                 = 1'b1;
      end else if (req.left_sample > lfps_pkg::DEEP_LEVEL
                   && req.center_sample < lfps_pkg::DEEP_LEVEL
                   && req.right_sample > lfps_pkg::DEEP_LEVEL) begin
         // both sides dark with a light center
         state_next.held_direction = lfps_pkg::DIR_SOFT_LEFT;
         rsp.dwell                 = 1'b1;
      end else begin
         rsp.left_speed  = held_l;
         rsp.right_speed = held_r;
      end
      rsp.wheel_direction = state_next.held_direction;
   end

endmodule

[design/line_follow_pid_steering.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// PID line follower steering: sensor samples in, wheel direction and speeds out.
// ----------------------------------------------------------------------------
// a sample is held in the input register, then its result in the result register
// throughput: one sample per cycle while the output is not stalled, set by the single input and result register
// while a result waits, the input register takes one more sample, then stalls
// reset: synchronous; clears integral, last error, held speeds and direction
// (stop), loads register defaults and empties both pipeline registers
module line_follow_pid_steering (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lfps_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lfps_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfps_pkg::CSR_DATA_W-1:0] csr_data
);

   lfps_pkg::cfg_type                 cfg;
   lfps_pkg::req_type                 in_data_ff;
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   lfps_pkg::rsp_type                 rsp_data_ff;
   lfps_pkg::rsp_type                 rsp_result;
   lfps_pkg::pid_state_type           pid_state_ff;
   lfps_pkg::pid_state_type           pid_state_in;
   lfps_pkg::steer_state_type         steer_state_ff;
   lfps_pkg::steer_state_type         steer_state_in;
   logic signed [lfps_pkg::PID_W-1:0] pid;
   logic                              advance;
   logic                              step;

   lfps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lfps_pid u_pid (
      .req        (in_data_ff),
      .cfg        (cfg),
      .state      (pid_state_ff),
      .state_next (pid_state_in),
      .pid        (pid)
   );

   lfps_steer u_steer (
      .req        (in_data_ff),
      .cfg        (cfg),
      .pid        (pid),
      .state      (steer_state_ff),
      .state_next (steer_state_in),
      .rsp        (rsp_result)
   );

   // handshake: result register frees up when empty or taken
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign step         = in_valid_ff && advance;
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // pipeline control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pid_state_ff   <= '0;
         steer_state_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            pid_state_ff   <= pid_state_in;
            steer_state_ff <= steer_state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= rsp_result;
      end
   end

   // a taken result with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !rsp_valid)
      else $error("result register did not drain");

   // controller state moves only when a sample is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(pid_state_ff) && $stable(steer_state_ff)))
      else $error("controller state changed without a sample");

   // dwell only comes with forward or soft-left patterns
   a_dwell_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dwell) |->
         (rsp_data.wheel_direction == lfps_pkg::DIR_FORWARD
          || rsp_data.wheel_direction == lfps_pkg::DIR_SOFT_LEFT))
      else $error("dwell raised with a wrong direction");

   // a stall on the input side means a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with a free result register");

endmodule
